>>> hw/rtl/hsl2rgb_pkg.sv
`timescale 1ns / 1ps

package hsl2rgb_pkg;

   localparam int FRAC_BITS = 16;
   // one extra bit so 1.0 itself fits (q can reach full scale)
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int PROD_W    = 2 * VAL_W;

   typedef logic [FRAC_BITS-1:0] frac_type;
   typedef logic [VAL_W-1:0]     val_type;
   typedef logic [PROD_W-1:0]    prod_type;

   localparam val_type  FX_ONE   = val_type'(1) << FRAC_BITS;
   localparam frac_type FX_THIRD = frac_type'((2 ** FRAC_BITS + 1) / 3);
   localparam frac_type FX_MAX   = '1;

endpackage

>>> hw/rtl/hsl2rgb_channel.sv
`timescale 1ns / 1ps

// One color channel: ramp factor from the shifted hue, scale by (q - p),
// add p and clamp. Three register stages, aligned with the top level.
module hsl2rgb_channel (
   input  logic                  clock,
   input  hsl2rgb_pkg::frac_type t_s1,
   input  hsl2rgb_pkg::val_type  p_s2,
   input  hsl2rgb_pkg::val_type  d_s2,
   output hsl2rgb_pkg::frac_type chan_out
);

   localparam int FW = hsl2rgb_pkg::FRAC_BITS;
   localparam int VW = hsl2rgb_pkg::VAL_W;
   localparam int PW = hsl2rgb_pkg::PROD_W;
   localparam int TW = FW + 3;

   logic [TW-1:0]        t1;
   logic [TW-1:0]        t2;
   logic [TW-1:0]        t3;
   logic [TW-1:0]        t6;
   logic [TW-1:0]        one_w;
   logic [TW-1:0]        fall;
   hsl2rgb_pkg::val_type factor_in, factor_ff;

   hsl2rgb_pkg::prod_type prod_in, prod_ff;
   hsl2rgb_pkg::val_type  p_s3_ff;

   logic [VW+1:0]         sum;
   hsl2rgb_pkg::frac_type chan_in, chan_ff;

   // stage 2: piecewise factor, (q-p)*factor >> FW gives the channel offset
   always_comb begin
      t1    = TW'(t_s1);
      t2    = t1 << 1;
      t3    = t1 + t2;
      t6    = t3 << 1;
      one_w = TW'(hsl2rgb_pkg::FX_ONE);
      fall  = ((one_w << 1) - t3) << 1;
      if (t6 < one_w) begin
         factor_in = VW'(t6);
      end else if (t2 < one_w) begin
         factor_in = hsl2rgb_pkg::FX_ONE;
      end else if (t3 < (one_w << 1)) begin
         factor_in = VW'(fall);
      end else begin
         factor_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      factor_ff <= factor_in;
   end

   // stage 3: multiply
   assign prod_in = PW'(d_s2) * PW'(factor_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      p_s3_ff <= p_s2;
   end

   // stage 4: add p and clamp to full scale
   always_comb begin
      sum = (VW + 2)'(p_s3_ff) + (VW + 2)'(prod_ff[PW-1:FW]);
      if (sum > (VW + 2)'(hsl2rgb_pkg::FX_MAX)) begin
         chan_in = hsl2rgb_pkg::FX_MAX;
      end else begin
         chan_in = sum[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
   end

   assign chan_out = chan_ff;

endmodule

>>> hw/rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// HSL to RGB, Q0.16 in and out.
// rsp_valid follows start through the stage valid bits, in step with the result registers.
// Throughput: one transaction per clock; four register stages
// (lightness*saturation product, q/p and ramp factor, channel multiply, add/clamp).
// busy is never raised; results are shown for one cycle on rsp_valid.
// Reset clears the stage valid bits only; no result appears until a new start.
module hsl_to_rgb_converter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  hsl2rgb_pkg::frac_type req_hue,
   input  hsl2rgb_pkg::frac_type req_saturation,
   input  hsl2rgb_pkg::frac_type req_lightness,
   output logic                  rsp_valid,
   output hsl2rgb_pkg::frac_type rsp_red,
   output hsl2rgb_pkg::frac_type rsp_green,
   output hsl2rgb_pkg::frac_type rsp_blue
);

   localparam int FW = hsl2rgb_pkg::FRAC_BITS;
   localparam int VW = hsl2rgb_pkg::VAL_W;

   logic [3:0] vld_in, vld_ff;

   // stage 1
   logic [2*FW-1:0]       ls_in, ls_ff;
   hsl2rgb_pkg::frac_type sat_ff;
   hsl2rgb_pkg::frac_type light_ff;
   hsl2rgb_pkg::frac_type t_red_in, t_red_ff;
   hsl2rgb_pkg::frac_type t_grn_ff;
   hsl2rgb_pkg::frac_type t_blu_in, t_blu_ff;

   // stage 2
   hsl2rgb_pkg::frac_type m;
   hsl2rgb_pkg::val_type  q;
   hsl2rgb_pkg::val_type  two_l;
   hsl2rgb_pkg::val_type  p_raw;
   hsl2rgb_pkg::val_type  p_in, p_ff;
   hsl2rgb_pkg::val_type  d_in, d_ff;

   assign busy = 1'b0;

   assign vld_in = {vld_ff[2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ls_in    = (2*FW)'(req_lightness) * (2*FW)'(req_saturation);
   assign t_red_in = req_hue + hsl2rgb_pkg::FX_THIRD;
   assign t_blu_in = req_hue - hsl2rgb_pkg::FX_THIRD;

   always_ff @(posedge clock) begin
      ls_ff    <= ls_in;
      sat_ff   <= req_saturation;
      light_ff <= req_lightness;
      t_red_ff <= t_red_in;
      t_grn_ff <= req_hue;
      t_blu_ff <= t_blu_in;
   end

   // q = l*(1+s) below one half, else l + s - l*s; p = 2l - q, kept in 0..q
   always_comb begin
      m = ls_ff[2*FW-1:FW];
      if (!light_ff[FW-1]) begin
         q = VW'(light_ff) + VW'(m);
      end else begin
         q = VW'(light_ff) + VW'(sat_ff) - VW'(m);
      end
      two_l = {light_ff, 1'b0};
      p_raw = (two_l >= q) ? (two_l - q) : '0;
      p_in  = (p_raw > q) ? q : p_raw;
      d_in  = q - p_in;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      d_ff <= d_in;
   end

   hsl2rgb_channel u_red (
      .clock    (clock),
      .t_s1     (t_red_ff),
      .p_s2     (p_ff),
      .d_s2     (d_ff),
      .chan_out (rsp_red)
   );

   hsl2rgb_channel u_green (
      .clock    (clock),
      .t_s1     (t_grn_ff),
      .p_s2     (p_ff),
      .d_s2     (d_ff),
      .chan_out (rsp_green)
   );

   hsl2rgb_channel u_blue (
      .clock    (clock),
      .t_s1     (t_blu_ff),
      .p_s2     (p_ff),
      .d_s2     (d_ff),
      .chan_out (rsp_blue)
   );

   assign rsp_valid = vld_ff[3];

endmodule
